// ===== rtl/dmis_pkg.sv =====
`default_nettype none

package dmis_pkg;

  localparam int CNT_W = 21;
  localparam int SUM_W = 36;
  localparam int SQ_W  = 52;

  // register indexes on the write port
  localparam logic [1:0] CFG_RANGE_LOW     = 2'd0;
  localparam logic [1:0] CFG_RANGE_HIGH    = 2'd1;
  localparam logic [1:0] CFG_DEPTH_LEVELS  = 2'd2;
  localparam logic [1:0] CFG_INLIER_FACTOR = 2'd3;

  localparam logic [7:0] MASK_ON  = 8'hff;
  localparam logic [7:0] MASK_OFF = 8'h00;

  typedef struct packed {
    logic [15:0] depth;
    logic        use_pixel;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  mask_value;
    logic [19:0] mode_mean;
    logic [19:0] std_dev;
    logic [15:0] min_depth;
    logic [15:0] max_depth;
    logic [19:0] avg_depth;
    logic [20:0] inlier_count;
    logic        frame_done;
    logic        none_found;
  } out_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [SUM_W-1:0] sum;
    logic [SQ_W-1:0]  sum_sq;
  } bin_ent_t;

endpackage

`default_nettype wire

// ===== rtl/depth_mode_inlier_segmenter.sv =====
`default_nettype none

// Mode-depth inlier segmenter. A frame is sent twice, one pixel per request on start
// while busy is low. Pass one builds a histogram of the in-use depths in a bin memory
// and gives no results; each pixel that lands in a bin goes through the
// one-bit-per-cycle divider that finds the bin index (25 steps), then a memory read
// and a write back. The last pixel of pass one then has the mode bin's mean and the
// deviation formed on the same divider, followed by a 30-step square root. Pass two
// gives one result per pixel, a request every cycle but for its last pixel, which,
// when there are inliers, keeps the block busy for the average divide. Results
// come as a one-cycle strobe on out_valid and cannot be held off by the receiver.
// The bin memory is cleared at once at reset and after every frame by per-bin
// valid flags, so there is no clearing pass.
module depth_mode_inlier_segmenter #(
  parameter int BINS         = 64,
  parameter int FRAME_PIXELS = 1048576,
  parameter int DEPTH_BITS   = 16
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start,
  output logic                  busy,
  input  dmis_pkg::in_item_t    in_data,
  output logic                  out_valid,
  output dmis_pkg::out_item_t   out_data,
  input  wire                   cfg_we,
  input  wire  [1:0]            cfg_index,
  input  wire  [15:0]           cfg_wdata
);
  import dmis_pkg::*;

  localparam int BIN_AW = (BINS > 1) ? $clog2(BINS) : 1;
  localparam logic [CNT_W-1:0] CAP =
    CNT_W'((FRAME_PIXELS < 1048576) ? FRAME_PIXELS : 1048576);
  localparam logic [15:0] DMASK = 16'((32'd1 << DEPTH_BITS) - 32'd1);
  localparam int NUM_W = 60;  // divider dividend / quotient
  localparam int DEN_W = 42;  // divider divisor / remainder
  localparam int SQX_W = 60;

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_BDIV = 4'd1;   // bin index divide
  localparam logic [3:0] S_BRD  = 4'd2;
  localparam logic [3:0] S_BWR  = 4'd3;
  localparam logic [3:0] S_FADR = 4'd4;   // end of pass one: read mode bin
  localparam logic [3:0] S_FRD  = 4'd5;
  localparam logic [3:0] S_FLAT = 4'd6;
  localparam logic [3:0] S_MDIV = 4'd7;   // mean
  localparam logic [3:0] S_QDIV = 4'd8;   // sum / count, remainder
  localparam logic [3:0] S_MUL  = 4'd9;
  localparam logic [3:0] S_ELD  = 4'd10;
  localparam logic [3:0] S_EDIV = 4'd11;
  localparam logic [3:0] S_RDIV = 4'd12;
  localparam logic [3:0] S_SQRT = 4'd13;
  localparam logic [3:0] S_ADIV = 4'd14;  // frame average

  // configuration
  logic [15:0] range_low_r, range_high_r;
  logic [8:0]  depth_levels_r;
  logic [7:0]  inlier_factor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r     <= 16'd0;
      range_high_r    <= 16'hffff;
      depth_levels_r  <= 9'd64;
      inlier_factor_r <= 8'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RANGE_LOW:     range_low_r     <= cfg_wdata;
        CFG_RANGE_HIGH:    range_high_r    <= cfg_wdata;
        CFG_DEPTH_LEVELS:  depth_levels_r  <= cfg_wdata[8:0];
        CFG_INLIER_FACTOR: inlier_factor_r <= cfg_wdata[7:0];
      endcase
    end
  end

  // control and frame state
  logic [3:0]        state_r;
  logic              phase_r;
  logic [BINS-1:0]   vld_r;
  logic [BIN_AW-1:0] addr_r;
  logic [BIN_AW-1:0] top_bin_r;
  logic [CNT_W-1:0]  top_count_r;
  logic [19:0]       mean_r, dev_r;
  logic              none_r;
  logic [15:0]       in_min_r, in_max_r;
  logic [SUM_W-1:0]  in_total_r;
  logic [CNT_W-1:0]  in_tally_r;
  logic              out_valid_r;
  out_item_t         out_r;

  // request payload kept for pass one
  logic [15:0] dep_r;
  logic        last_r;

  // shared serial divider and square root
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r, rem_r;
  logic [5:0]       step_r;
  logic [SQX_W-1:0] sqx_r, sqres_r, sqbit_r;

  // finishing operands
  logic [CNT_W-1:0] n_r;
  logic [SUM_W-1:0] s_r;
  logic [SQ_W-1:0]  sq_r;
  logic [15:0]      q_r;
  logic [CNT_W-1:0] r_r;
  logic [SQ_W:0]    sub_r;
  logic [DEN_W-1:0] rr_r, nn_r;
  logic [NUM_W-1:0] a_r;

  // bin memory
  bin_ent_t bin_mem [BINS];
  bin_ent_t rd_r;
  bin_ent_t cur_ent, wr_ent;
  logic     mem_we;
  logic [31:0] dep_sq;

  always_comb begin
    cur_ent = vld_r[addr_r] ? rd_r : '0;
    dep_sq  = 32'(dep_r) * 32'(dep_r);
    wr_ent.count  = cur_ent.count + CNT_W'(1);
    wr_ent.sum    = cur_ent.sum + SUM_W'(dep_r);
    wr_ent.sum_sq = cur_ent.sum_sq + SQ_W'(dep_sq);
    mem_we = (state_r == S_BWR) && (cur_ent.count < CAP);
  end

  always_ff @(posedge clk) begin
    if (mem_we) bin_mem[addr_r] <= wr_ent;
    rd_r <= bin_mem[addr_r];
  end

  // divider step: restoring, one quotient bit per cycle
  logic [DEN_W:0]   rem_sh;
  logic             q_bit;
  logic [DEN_W-1:0] rem_nxt;
  logic [NUM_W-1:0] num_nxt;

  always_comb begin
    rem_sh  = {rem_r, num_r[NUM_W-1]};
    q_bit   = rem_sh >= {1'b0, den_r};
    rem_nxt = q_bit ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
    num_nxt = {num_r[NUM_W-2:0], q_bit};
  end

  // square root step
  logic [SQX_W-1:0] sq_try;
  logic             sq_ge;

  always_comb begin
    sq_try = sqres_r + sqbit_r;
    sq_ge  = sqx_r >= sq_try;
  end

  // request side decode
  logic [15:0] dep_in;
  logic [8:0]  lv;
  logic        bin_elig;
  logic [24:0] bin_num;

  always_comb begin
    dep_in = in_data.depth & DMASK;
    priority if (depth_levels_r == 9'd0) lv = 9'd1;
    else if (depth_levels_r > 9'(BINS))  lv = 9'(BINS);
    else                                 lv = depth_levels_r;
    bin_elig = in_data.use_pixel && (dep_in != 16'd0) && (range_high_r > range_low_r)
               && (dep_in >= range_low_r) && (dep_in < range_high_r);
    bin_num  = 25'(dep_in - range_low_r) * 25'(lv);
  end

  // pass two inlier test and running statistics
  logic [19:0]      d16, diff;
  logic [27:0]      thr;
  logic             inlier;
  logic [15:0]      min_nxt, max_nxt;
  logic [SUM_W-1:0] total_nxt;
  logic [CNT_W-1:0] tally_nxt;
  logic [40:0]      avg_num;

  always_comb begin
    d16    = {dep_in, 4'b0};
    diff   = (d16 >= mean_r) ? d16 - mean_r : mean_r - d16;
    thr    = 28'(inlier_factor_r) * 28'(dev_r);
    inlier = !none_r && (dep_in != 16'd0) && ({4'b0, diff, 4'b0} < thr);
    min_nxt   = in_min_r;
    max_nxt   = in_max_r;
    total_nxt = in_total_r;
    tally_nxt = in_tally_r;
    if (inlier) begin
      if (dep_in < in_min_r) min_nxt = dep_in;
      if (dep_in > in_max_r) max_nxt = dep_in;
      if (in_tally_r < CAP) begin
        tally_nxt = in_tally_r + CNT_W'(1);
        total_nxt = in_total_r + SUM_W'(dep_in);
      end
    end
    avg_num = {1'b0, total_nxt, 4'b0} + 41'(tally_nxt >> 1);
  end

  // end of pass one helpers
  logic [40:0]     mean_num;
  logic [SQ_W-1:0] e_val;
  logic [NUM_W-1:0] v_val;

  always_comb begin
    mean_num = {1'b0, cur_ent.sum, 4'b0} + 41'(cur_ent.count >> 1);
    e_val    = ({1'b0, sq_r} >= sub_r) ? SQ_W'({1'b0, sq_r} - sub_r) : '0;
    v_val    = (a_r > num_r) ? a_r - num_r : '0;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= 1'b0;
      vld_r       <= '0;
      top_bin_r   <= '0;
      top_count_r <= '0;
      mean_r      <= '0;
      dev_r       <= '0;
      none_r      <= 1'b1;
      in_min_r    <= 16'hffff;
      in_max_r    <= '0;
      in_total_r  <= '0;
      in_tally_r  <= '0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            dep_r  <= dep_in;
            last_r <= in_data.last;
            if (!phase_r) begin
              // pass one: bin index by serial divide
              if (bin_elig) begin
                num_r   <= {bin_num, 35'b0};
                den_r   <= DEN_W'(range_high_r - range_low_r);
                rem_r   <= '0;
                step_r  <= 6'd25;
                state_r <= S_BDIV;
              end else if (in_data.last) begin
                state_r <= S_FADR;
              end
            end else begin
              // running statistics only carry on within the frame
              if (!in_data.last) begin
                in_min_r   <= min_nxt;
                in_max_r   <= max_nxt;
                in_total_r <= total_nxt;
                in_tally_r <= tally_nxt;
              end
              out_r.mask_value   <= inlier ? MASK_ON : MASK_OFF;
              out_r.mode_mean    <= mean_r;
              out_r.std_dev      <= dev_r;
              out_r.min_depth    <= min_nxt;
              out_r.max_depth    <= max_nxt;
              out_r.avg_depth    <= '0;
              out_r.inlier_count <= tally_nxt;
              out_r.frame_done   <= in_data.last;
              out_r.none_found   <= none_r;
              if (in_data.last && (tally_nxt != '0)) begin
                num_r   <= {avg_num, 19'b0};
                den_r   <= DEN_W'(tally_nxt);
                rem_r   <= '0;
                step_r  <= 6'd41;
                state_r <= S_ADIV;
              end else begin
                out_valid_r <= 1'b1;
                if (in_data.last) begin
                  // frame over: back to histogram pass
                  vld_r       <= '0;
                  top_bin_r   <= '0;
                  top_count_r <= '0;
                  in_min_r    <= 16'hffff;
                  in_max_r    <= '0;
                  in_total_r  <= '0;
                  in_tally_r  <= '0;
                  phase_r     <= 1'b0;
                end
              end
            end
          end
        end
        S_BDIV: begin
          if (step_r != 6'd0) begin
            num_r  <= num_nxt;
            rem_r  <= rem_nxt;
            step_r <= step_r - 6'd1;
          end else if (num_r < NUM_W'(lv)) begin
            addr_r  <= num_r[BIN_AW-1:0];
            state_r <= S_BRD;
          end else begin
            state_r <= last_r ? S_FADR : S_IDLE;
          end
        end
        S_BRD: state_r <= S_BWR;
        S_BWR: begin
          if (mem_we) begin
            vld_r[addr_r] <= 1'b1;
            if (wr_ent.count > top_count_r) begin
              top_count_r <= wr_ent.count;
              top_bin_r   <= addr_r;
            end
          end
          state_r <= last_r ? S_FADR : S_IDLE;
        end
        S_FADR: begin
          addr_r  <= top_bin_r;
          state_r <= S_FRD;
        end
        S_FRD: state_r <= S_FLAT;
        S_FLAT: begin
          n_r  <= cur_ent.count;
          s_r  <= cur_ent.sum;
          sq_r <= cur_ent.sum_sq;
          if ((top_count_r == '0) || (cur_ent.count == '0) ||
              (range_high_r <= range_low_r)) begin
            none_r  <= 1'b1;
            mean_r  <= '0;
            dev_r   <= '0;
            phase_r <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            num_r   <= {mean_num, 19'b0};
            den_r   <= DEN_W'(cur_ent.count);
            rem_r   <= '0;
            step_r  <= 6'd41;
            state_r <= S_MDIV;
          end
        end
        S_MDIV: begin
          if (step_r != 6'd0) begin
            num_r  <= num_nxt;
            rem_r  <= rem_nxt;
            step_r <= step_r - 6'd1;
          end else begin
            mean_r  <= num_r[19:0];
            num_r   <= {s_r, 24'b0};
            rem_r   <= '0;
            step_r  <= 6'd36;
            state_r <= S_QDIV;
          end
        end
        S_QDIV: begin
          if (step_r != 6'd0) begin
            num_r  <= num_nxt;
            rem_r  <= rem_nxt;
            step_r <= step_r - 6'd1;
          end else begin
            q_r     <= num_r[15:0];
            r_r     <= rem_r[CNT_W-1:0];
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          sub_r   <= (SQ_W+1)'(q_r) * (SQ_W+1)'({1'b0, s_r} + 37'(r_r));
          rr_r    <= DEN_W'(r_r) * DEN_W'(r_r);
          nn_r    <= DEN_W'(n_r) * DEN_W'(n_r);
          state_r <= S_ELD;
        end
        S_ELD: begin
          num_r   <= {e_val, 8'b0};
          den_r   <= DEN_W'(n_r);
          rem_r   <= '0;
          step_r  <= 6'd60;
          state_r <= S_EDIV;
        end
        S_EDIV: begin
          if (step_r != 6'd0) begin
            num_r  <= num_nxt;
            rem_r  <= rem_nxt;
            step_r <= step_r - 6'd1;
          end else begin
            a_r     <= num_r;
            num_r   <= {rr_r, 8'b0, 10'b0};
            den_r   <= nn_r;
            rem_r   <= '0;
            step_r  <= 6'd50;
            state_r <= S_RDIV;
          end
        end
        S_RDIV: begin
          if (step_r != 6'd0) begin
            num_r  <= num_nxt;
            rem_r  <= rem_nxt;
            step_r <= step_r - 6'd1;
          end else begin
            sqx_r   <= v_val;
            sqres_r <= '0;
            sqbit_r <= SQX_W'(1) << (SQX_W - 2);
            step_r  <= 6'(SQX_W / 2);
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (step_r != 6'd0) begin
            if (sq_ge) begin
              sqx_r   <= sqx_r - sq_try;
              sqres_r <= (sqres_r >> 1) + sqbit_r;
            end else begin
              sqres_r <= sqres_r >> 1;
            end
            sqbit_r <= sqbit_r >> 2;
            step_r  <= step_r - 6'd1;
          end else begin
            dev_r   <= sqres_r[19:0];
            none_r  <= 1'b0;
            phase_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        S_ADIV: begin
          if (step_r != 6'd0) begin
            num_r  <= num_nxt;
            rem_r  <= rem_nxt;
            step_r <= step_r - 6'd1;
          end else begin
            out_r.avg_depth <= num_r[19:0];
            out_valid_r <= 1'b1;
            vld_r       <= '0;
            top_bin_r   <= '0;
            top_count_r <= '0;
            in_min_r    <= 16'hffff;
            in_max_r    <= '0;
            in_total_r  <= '0;
            in_tally_r  <= '0;
            phase_r     <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dmis_checker.sv =====
`default_nettype none

module dmis_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 out_valid,
  input dmis_pkg::out_item_t out_data
);
  import dmis_pkg::*;

  // nothing comes out right after reset
  a_no_result_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  // no mode found means no inlier
  a_none_masks_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.none_found |-> out_data.mask_value == MASK_OFF)
    else $error("inlier while nothing found");

  // an inlier is counted and bounds the min and max
  a_inlier_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.mask_value == MASK_ON |->
      out_data.inlier_count != '0 && out_data.min_depth <= out_data.max_depth)
    else $error("inlier not reflected in statistics");

  // average only on the frame's last result
  a_avg_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.frame_done |-> out_data.avg_depth == '0)
    else $error("average outside frame end");

  // mask is either of its two codes
  a_mask_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.mask_value == MASK_ON || out_data.mask_value == MASK_OFF)
    else $error("bad mask code");

endmodule

bind depth_mode_inlier_segmenter dmis_checker u_dmis_checker (.*);

`default_nettype wire

// ===== test/tb_depth_mode_inlier_segmenter.sv =====
`timescale 1ns / 1ps

module tb_depth_mode_inlier_segmenter;
  import dmis_pkg::*;

  localparam int          NBINS    = 64;
  localparam longint unsigned CAP  = 1048576;
  localparam int          SETTLE   = 300;   // covers the end of pass one

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_data = '0;
  logic        out_valid;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_RANGE_LOW;
  logic [15:0] cfg_wdata = '0;

  depth_mode_inlier_segmenter i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // pixel requests waiting for the driver, mask results waiting for the block
  in_item_t  pixel_q[$];
  out_item_t mask_q[$];

  int  errors = 0;
  int  requests_sent = 0;
  int  frames_seen = 0;
  int  empty_frames = 0;
  int  inliers_seen = 0;
  bit  no_idle = 1'b0;

  // register copies
  longint unsigned range_lo = 0, range_hi = 65535, levels = 64, factor = 16;

  // histogram and mask state of the prediction
  bit              second_pass;
  longint unsigned hist_cnt[NBINS], hist_sum[NBINS], hist_sq[NBINS];
  int unsigned     mode_bin;
  longint unsigned mode_cnt, mean_q4, dev_q4;
  longint unsigned in_min, in_max, in_total, in_tally;
  bit              nothing_found;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic void new_frame();
    for (int i = 0; i < NBINS; i++) begin
      hist_cnt[i] = 0;
      hist_sum[i] = 0;
      hist_sq[i]  = 0;
    end
    mode_bin = 0;
    mode_cnt = 0;
    in_min = 64'hffff;
    in_max = 0;
    in_total = 0;
    in_tally = 0;
    second_pass = 1'b0;
  endfunction

  // mean and deviation of the mode bin, formed at the end of the histogram pass
  function automatic void mode_stats();
    longint unsigned n, s, sq, q, r, sub, e, a, b, v;
    n  = hist_cnt[mode_bin % NBINS];
    s  = hist_sum[mode_bin % NBINS];
    sq = hist_sq[mode_bin % NBINS];
    if (mode_cnt == 0 || n == 0 || range_hi <= range_lo) begin
      nothing_found = 1'b1;
      mean_q4 = 0;
      dev_q4 = 0;
      return;
    end
    nothing_found = 1'b0;
    mean_q4 = ((s << 4) + (n >> 1)) / n;
    q = s / n;
    r = s % n;
    sub = q * (s + r);
    e = (sq >= sub) ? sq - sub : 0;
    a = (e << 8) / n;
    b = ((r * r) << 8) / (n * n);
    v = (a > b) ? a - b : 0;
    dev_q4 = int_sqrt(v) & 20'hfffff;
  endfunction

  // returns 1 when the pixel produces a mask result
  function automatic bit segment_pixel(input in_item_t px, output out_item_t res);
    longint unsigned d, lv, bn, d16, diff, avg;
    bit is_in;
    d = 64'(px.depth);
    res = '0;
    if (!second_pass) begin
      lv = levels;
      if (lv < 1) lv = 1;
      if (lv > NBINS) lv = NBINS;
      if (px.use_pixel && d != 0 && range_hi > range_lo && d >= range_lo && d < range_hi) begin
        bn = (d - range_lo) * lv / (range_hi - range_lo);
        if (bn < lv && hist_cnt[bn] < CAP) begin
          hist_cnt[bn]++;
          hist_sum[bn] += d;
          hist_sq[bn]  += d * d;
          if (hist_cnt[bn] > mode_cnt) begin
            mode_cnt = hist_cnt[bn];
            mode_bin = 32'(bn);
          end
        end
      end
      if (px.last) begin
        mode_stats();
        second_pass = 1'b1;
      end
      return 1'b0;
    end
    is_in = 1'b0;
    avg = 0;
    if (!nothing_found && d != 0) begin
      d16 = d << 4;
      diff = (d16 >= mean_q4) ? d16 - mean_q4 : mean_q4 - d16;
      is_in = (diff << 4) < factor * dev_q4;
    end
    if (is_in) begin
      if (d < in_min) in_min = d;
      if (d > in_max) in_max = d;
      if (in_tally < CAP) begin
        in_tally++;
        in_total += d;
      end
    end
    if (px.last && in_tally != 0) avg = ((in_total << 4) + (in_tally >> 1)) / in_tally;
    res.mask_value   = is_in ? MASK_ON : MASK_OFF;
    res.mode_mean    = mean_q4[19:0];
    res.std_dev      = dev_q4[19:0];
    res.min_depth    = in_min[15:0];
    res.max_depth    = in_max[15:0];
    res.avg_depth    = avg[19:0];
    res.inlier_count = in_tally[20:0];
    res.frame_done   = px.last;
    res.none_found   = nothing_found;
    if (px.last) new_frame();
    return 1'b1;
  endfunction

  function automatic void check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // driver: present the next pixel once the current one is taken, idling at random
  always @(posedge clk) begin
    bit free;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      free = !start || !busy;
      if (free) begin
        if (pixel_q.size() > 0 && (no_idle || $urandom_range(0, 99) >= 20)) begin
          start   <= 1'b1;
          in_data <= pixel_q.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: predict on every accepted request, then check any result strobe
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n) begin
      if (start && !busy) begin
        requests_sent++;
        if (segment_pixel(in_data, exp_r)) mask_q.insert(mask_q.size(), exp_r);
      end
      if (out_valid) begin
        if (mask_q.size() == 0) begin
          $error("unexpected result strobe");
          errors++;
        end else begin
          exp_r = mask_q.pop_front();
          check_field("mask_value", exp_r.mask_value, out_data.mask_value);
          check_field("mode_mean", exp_r.mode_mean, out_data.mode_mean);
          check_field("std_dev", exp_r.std_dev, out_data.std_dev);
          check_field("min_depth", exp_r.min_depth, out_data.min_depth);
          check_field("max_depth", exp_r.max_depth, out_data.max_depth);
          check_field("avg_depth", exp_r.avg_depth, out_data.avg_depth);
          check_field("inlier_count", exp_r.inlier_count, out_data.inlier_count);
          check_field("frame_done", exp_r.frame_done, out_data.frame_done);
          check_field("none_found", exp_r.none_found, out_data.none_found);
          if (exp_r.mask_value == MASK_ON) inliers_seen++;
          if (exp_r.frame_done) begin
            frames_seen++;
            if (exp_r.none_found) empty_frames++;
          end
        end
      end
    end
  end

  // sender holds off until the block has drained, then lets the end of pass one settle
  task automatic wait_drained();
    while (!(pixel_q.size() == 0 && !start && mask_q.size() == 0)) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_RANGE_LOW:     range_lo = 64'(val);
      CFG_RANGE_HIGH:    range_hi = 64'(val);
      CFG_DEPTH_LEVELS:  levels   = 64'(val[8:0]);
      CFG_INLIER_FACTOR: factor   = 64'(val[7:0]);
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_pixel(int d, bit use_it, bit lst);
    in_item_t px;
    px.depth = d[15:0];
    px.use_pixel = use_it;
    px.last = lst;
    pixel_q.insert(pixel_q.size(), px);
  endtask

  // clustered depth around the frame's center, with some noise and missing samples
  function automatic int pick_depth(int center, int spread);
    int v;
    if ($urandom_range(0, 99) < 5) return 0;
    if ($urandom_range(0, 99) < 15) return $urandom_range(0, 65535);
    v = center + $urandom_range(0, 2 * spread) - spread;
    if (v < 1) v = 1;
    if (v > 65535) v = 65535;
    return v;
  endfunction

  // one frame: histogram pass then mask pass, mostly well formed
  task automatic random_frame(output int n_items);
    int center, spread, n1, n2;
    center = (range_hi > range_lo) ? $urandom_range(32'(range_lo), 32'(range_hi - 1))
                                   : $urandom_range(1, 65535);
    spread = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 2000);
    n1 = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 30);
    n2 = $urandom_range(1, 30);
    for (int i = 0; i < n1; i++)
      push_pixel(pick_depth(center, spread), $urandom_range(0, 9) != 0, i == n1 - 1);
    for (int i = 0; i < n2; i++)
      push_pixel(pick_depth(center, spread), $urandom_range(0, 1) != 0, i == n2 - 1);
    n_items = n1 + n2;
  endtask

  initial begin
    int got, phase_items;
    logic [15:0] lo, hi;
    new_frame();
    nothing_found = 1'b1;
    mean_q4 = 0;
    dev_q4 = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, extremes of depth, unused and missing samples
    push_pixel(1000, 1, 0);
    push_pixel(1000, 1, 0);
    push_pixel(1010, 1, 0);
    push_pixel(65535, 1, 0);
    push_pixel(0, 1, 0);
    push_pixel(2000, 0, 0);
    push_pixel(1, 1, 1);
    push_pixel(1000, 1, 0);
    push_pixel(1005, 0, 0);
    push_pixel(0, 1, 0);
    push_pixel(65535, 1, 0);
    push_pixel(1, 1, 1);
    // every binned sample identical, so zero deviation
    push_pixel(500, 1, 0);
    push_pixel(500, 1, 1);
    push_pixel(500, 1, 1);
    // nothing binned
    push_pixel(700, 0, 0);
    push_pixel(0, 1, 1);
    push_pixel(700, 1, 1);
    wait_drained();

    // register settings, extremes first, then random
    for (int p = 0; p < 12; p++) begin
      case (p)
        0: begin write_reg(CFG_RANGE_LOW, 0);     write_reg(CFG_RANGE_HIGH, 65535);
                 write_reg(CFG_DEPTH_LEVELS, 64); write_reg(CFG_INLIER_FACTOR, 16); end
        1: begin write_reg(CFG_DEPTH_LEVELS, 1);  write_reg(CFG_INLIER_FACTOR, 255); end
        2: begin write_reg(CFG_RANGE_LOW, 65535); write_reg(CFG_RANGE_HIGH, 0);
                 write_reg(CFG_DEPTH_LEVELS, 256); end
        3: begin write_reg(CFG_RANGE_LOW, 1000);  write_reg(CFG_RANGE_HIGH, 1000);
                 write_reg(CFG_DEPTH_LEVELS, 511); write_reg(CFG_INLIER_FACTOR, 100); end
        4: begin write_reg(CFG_RANGE_LOW, 0);     write_reg(CFG_RANGE_HIGH, 65535);
                 write_reg(CFG_DEPTH_LEVELS, 0);   write_reg(CFG_INLIER_FACTOR, 0); end
        5: begin write_reg(CFG_RANGE_LOW, 65534); write_reg(CFG_RANGE_HIGH, 65535);
                 write_reg(CFG_DEPTH_LEVELS, 64);  write_reg(CFG_INLIER_FACTOR, 40); end
        default: begin
          lo = 16'($urandom_range(0, 60000));
          hi = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                           : lo + 16'($urandom_range(1, 65535 - lo));
          write_reg(CFG_RANGE_LOW, lo);
          write_reg(CFG_RANGE_HIGH, hi);
          write_reg(CFG_DEPTH_LEVELS, 16'($urandom_range(0, 511)));
          write_reg(CFG_INLIER_FACTOR, 16'($urandom_range(0, 255)));
        end
      endcase
      no_idle = (p == 6);
      phase_items = 0;
      while (phase_items < 130) begin
        random_frame(got);
        phase_items += got;
      end
      wait_drained();
    end
    no_idle = 1'b0;

    $display("covered %0d pixel requests over %0d frames (%0d with no mode found)",
             requests_sent, frames_seen, empty_frames);
    $display("%0d inlier masks checked across twelve register settings", inliers_seen);
    if (errors == 0 && mask_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dmis_pkg.sv
rtl/depth_mode_inlier_segmenter.sv
rtl/dmis_checker.sv
test/tb_depth_mode_inlier_segmenter.sv
